FILE: design/cra_pkg.sv
// Shared constants and types of the checked rational ALU.
package cra_pkg;

	localparam int WORD_WIDTH_DEF = 64;

	localparam logic [3:0] MODE_ADD   = 4'd0;
	localparam logic [3:0] MODE_SUB   = 4'd1;
	localparam logic [3:0] MODE_MUL   = 4'd2;
	localparam logic [3:0] MODE_DIV   = 4'd3;
	localparam logic [3:0] MODE_NEG   = 4'd4;
	localparam logic [3:0] MODE_LT    = 4'd5;
	localparam logic [3:0] MODE_LE    = 4'd6;
	localparam logic [3:0] MODE_GT    = 4'd7;
	localparam logic [3:0] MODE_GE    = 4'd8;
	localparam logic [3:0] MODE_EQ    = 4'd9;
	localparam logic [3:0] MODE_NE    = 4'd10;
	localparam logic [3:0] MODE_FLOOR = 4'd11;
	localparam logic [3:0] MODE_NORM  = 4'd12;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_OVF  = 2'd1;
	localparam logic [1:0] STAT_ZDEN = 2'd2;

	// request to the shared multiply / divide unit
	typedef struct packed {
		logic start;
		logic div;
	} cra_req_t;

endpackage

FILE: design/cra_in_if.sv
// Input channel of the checked rational ALU: mode and two fractions.
interface cra_in_if;
	logic        valid;
	logic        ready;
	logic [3:0]  mode;
	logic [63:0] a_num;
	logic [63:0] a_den;
	logic [63:0] b_num;
	logic [62:0] b_den;

	modport source (output valid, mode, a_num, a_den, b_num, b_den, input ready);
	modport sink (input valid, mode, a_num, a_den, b_num, b_den, output ready);
endinterface

FILE: design/cra_out_if.sv
// Output channel of the checked rational ALU: result fraction, truth and status.
interface cra_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_num;
	logic [62:0] result_den;
	logic        truth;
	logic [1:0]  status;

	modport source (output valid, result_num, result_den, truth, status, input ready);
	modport sink (input valid, result_num, result_den, truth, status, output ready);
endinterface

FILE: design/cra_muldiv.sv
// Shared radix-2 unit: unsigned shift-add multiply and restoring divide on one adder.
module cra_muldiv
	import cra_pkg::*;
#(
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cra_req_t                  req,
	input  logic [WORD_WIDTH-1:0]     a,
	input  logic [WORD_WIDTH-1:0]     b,
	output logic                      done,
	output logic [2*WORD_WIDTH-1:0]   prod,
	output logic [WORD_WIDTH-1:0]     quot,
	output logic [WORD_WIDTH-1:0]     rem
);
	localparam int W  = WORD_WIDTH;
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  hi_q, lo_q, m_q;
	logic          div_q, busy_q, done_q;
	logic [CW-1:0] cnt_q;
	logic [W:0]    x, y, s;
	logic [W+1:0]  sum;
	logic          carry;

	always_comb begin
		x     = div_q ? {hi_q, lo_q[W-1]} : {1'b0, hi_q};
		y     = div_q ? ~{1'b0, m_q} : {1'b0, m_q};
		sum   = {1'b0, x} + {1'b0, y} + (W+2)'(div_q);
		carry = sum[W+1];
		s     = lo_q[0] ? sum[W:0] : {1'b0, hi_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			hi_q  <= '0;
			lo_q  <= a;
			m_q   <= b;
			div_q <= req.div;
		end else if (busy_q) begin
			if (div_q) begin
				// subtract when the partial remainder covers the divisor
				hi_q <= carry ? sum[W-1:0] : x[W-1:0];
				lo_q <= {lo_q[W-2:0], carry};
			end else begin
				hi_q <= s[W:1];
				lo_q <= {s[0], lo_q[W-1:1]};
			end
		end
	end

	assign done = done_q;
	assign prod = {hi_q, lo_q};
	assign quot = lo_q;
	assign rem  = hi_q;

endmodule

FILE: design/checked_rational_alu.sv
// Top level of the checked rational ALU: sequencer around a shared multiply / divide unit.
//
// Use: req carries a mode and two fractions a = a_num/a_den, b = b_num/b_den; rsp returns one
// item per request with result_num/result_den, a comparison bit (truth) and a status
// (ok, overflow, zero denominator). On any error the result reads 0/1 with truth low.
// Only the low WORD_WIDTH bits of each operand are used, as signed words; b_den is zero-extended.
//
// Timing: one item at a time. req.ready is high only while the block is idle; after an item
// is taken, req.ready stays low until its result has been taken on rsp, and the next item
// can be taken in the cycle after that. All multiplies and divides run on one radix-2
// multiply / divide unit; each product first sets up its operands in the S_MISS state.
// Work per mode:
//   neg, eq, ne, unused modes: done in the dispatch state, without the unit
//   floor: one division
//   lt, le, gt, ge: two products
//   add, sub, mul, div, normalize: up to three products, then one remainder step per
//   Euclid iteration and two exact divisions.
// Reset: arst_n clears the sequencer to idle; no item is in flight after reset.
// Stall: a result waits in the output registers with rsp.valid high until rsp.ready.
module checked_rational_alu
	import cra_pkg::*;
#(
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	cra_in_if.sink    req,
	cra_out_if.source rsp
);
	localparam int W = WORD_WIDTH;
	localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_DISP  = 10'b0000000010,
		S_MISS  = 10'b0000000100,
		S_MUL   = 10'b0000001000,
		S_NORM  = 10'b0000010000,
		S_GCD   = 10'b0000100000,
		S_DIVN  = 10'b0001000000,
		S_DIVD  = 10'b0010000000,
		S_FLOOR = 10'b0100000000,
		S_DONE  = 10'b1000000000
	} state_t;

	state_t state_q;

	logic [3:0]          mode_q;
	logic signed [W-1:0] an_q, ad_q, bn_q, bd_q;
	logic signed [W-1:0] p1_q, n_q, d_q, rn_q, rd_q;
	logic [W-1:0]        ua_q, ub_q, g_q;
	logic [1:0]          k_q;
	logic                negr_q, div_q, go_q, truth_q;
	logic [1:0]          st_q;

	logic                md_done;
	logic [2*W-1:0]      md_prod;
	logic [W-1:0]        md_quot, md_rem;
	cra_req_t            md_req;

	function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
		mag = v[W-1] ? W'(-v) : v;
	endfunction

	assign md_req.start = go_q;
	assign md_req.div   = div_q;

	cra_muldiv #(.WORD_WIDTH(WORD_WIDTH)) u_muldiv (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (md_req),
		.a     (ua_q),
		.b     (ub_q),
		.done  (md_done),
		.prod  (md_prod),
		.quot  (md_quot),
		.rem   (md_rem)
	);

	// operand pair of the next product
	logic signed [W-1:0] ma, mb;
	always_comb begin
		ma = an_q;
		mb = bd_q;
		case (mode_q)
			MODE_ADD, MODE_SUB: begin
				case (k_q)
					2'd0:    begin ma = bn_q; mb = ad_q; end
					2'd1:    begin ma = an_q; mb = bd_q; end
					default: begin ma = ad_q; mb = bd_q; end
				endcase
			end
			MODE_MUL: begin
				if (k_q == 2'd0) begin ma = an_q; mb = bn_q; end
				else begin ma = ad_q; mb = bd_q; end
			end
			MODE_DIV: begin
				if (k_q == 2'd0) begin ma = an_q; mb = bd_q; end
				else begin ma = ad_q; mb = bn_q; end
			end
			default: begin
				if (k_q == 2'd0) begin ma = an_q; mb = bd_q; end
				else begin ma = bn_q; mb = ad_q; end
			end
		endcase
	end

	// signed value of the finished product and its range check; also sum, sign move and floor result
	logic signed [W-1:0] pv, asum, nn, dd;
	logic [W-1:0]        lim, fq;
	logic                pv_ovf, asum_ovf, norm_ovf, fneg;
	always_comb begin
		lim      = negr_q ? WMIN : WMAX;
		pv_ovf   = (|md_prod[2*W-1:W]) || (md_prod[W-1:0] > lim);
		pv       = negr_q ? W'(-md_prod[W-1:0]) : md_prod[W-1:0];
		asum     = pv + p1_q;
		asum_ovf = (pv[W-1] == p1_q[W-1]) && (asum[W-1] != pv[W-1]);
		norm_ovf = d_q[W-1] && (n_q == WMIN || d_q == WMIN);
		nn       = d_q[W-1] ? W'(-n_q) : n_q;
		dd       = d_q[W-1] ? W'(-d_q) : d_q;
		fq       = (an_q[W-1] ^ ad_q[W-1]) ? W'(-md_quot) : md_quot;
		fneg     = an_q[W-1] && (md_rem != '0);
	end

	assign req.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			go_q    <= 1'b0;
		end else begin
			go_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req.valid) state_q <= S_DISP;
				end
				S_DISP: begin
					case (mode_q)
						MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV,
						MODE_LT, MODE_LE, MODE_GT, MODE_GE: state_q <= S_MISS;
						MODE_FLOOR: begin
							if (ad_q == '0 || (an_q == WMIN && ad_q == '1)) begin
								state_q <= S_DONE;
							end else begin
								go_q    <= 1'b1;
								state_q <= S_FLOOR;
							end
						end
						MODE_NORM: state_q <= S_NORM;
						default:   state_q <= S_DONE;
					endcase
				end
				S_MISS: begin
					go_q    <= 1'b1;
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (md_done) begin
						if (pv_ovf) begin
							state_q <= S_DONE;
						end else if (k_q == 2'd0) begin
							if (mode_q == MODE_SUB && pv == WMIN) state_q <= S_DONE;
							else state_q <= S_MISS;
						end else if (k_q == 2'd1) begin
							case (mode_q)
								MODE_ADD, MODE_SUB:
									state_q <= asum_ovf ? S_DONE : S_MISS;
								MODE_MUL, MODE_DIV: state_q <= S_NORM;
								default:            state_q <= S_DONE;
							endcase
						end else begin
							state_q <= S_NORM;
						end
					end
				end
				S_NORM: begin
					if (d_q == '0 || norm_ovf || n_q == '0 || nn == WMIN) begin
						state_q <= S_DONE;
					end else begin
						go_q    <= 1'b1;
						state_q <= S_GCD;
					end
				end
				S_GCD: begin
					if (md_done) begin
						go_q <= 1'b1;
						if (md_rem == '0) state_q <= S_DIVN;
					end
				end
				S_DIVN: begin
					if (md_done) begin
						go_q    <= 1'b1;
						state_q <= S_DIVD;
					end
				end
				S_DIVD, S_FLOOR: begin
					if (md_done) state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp.ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath: operands, working values and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				mode_q  <= req.mode;
				an_q    <= req.a_num[W-1:0];
				ad_q    <= req.a_den[W-1:0];
				bn_q    <= req.b_num[W-1:0];
				bd_q    <= W'({1'b0, req.b_den});
				k_q     <= 2'd0;
				rn_q    <= '0;
				rd_q    <= W'(1);
				truth_q <= 1'b0;
				st_q    <= STAT_OK;
			end
			S_DISP: begin
				case (mode_q)
					MODE_NEG: begin
						if (an_q == WMIN) begin
							st_q <= STAT_OVF;
						end else begin
							rn_q <= -an_q;
							rd_q <= ad_q;
						end
					end
					MODE_EQ: truth_q <= (an_q == bn_q) && (ad_q == bd_q);
					MODE_NE: truth_q <= !((an_q == bn_q) && (ad_q == bd_q));
					MODE_FLOOR: begin
						if (ad_q == '0) st_q <= STAT_ZDEN;
						else if (an_q == WMIN && ad_q == '1) st_q <= STAT_OVF;
						ua_q  <= mag(an_q);
						ub_q  <= mag(ad_q);
						div_q <= 1'b1;
					end
					MODE_NORM: begin
						n_q <= an_q;
						d_q <= ad_q;
					end
					default: ;
				endcase
			end
			S_MISS: begin
				ua_q   <= mag(ma);
				ub_q   <= mag(mb);
				negr_q <= ma[W-1] ^ mb[W-1];
				div_q  <= 1'b0;
			end
			S_MUL: begin
				if (md_done) begin
					k_q <= k_q + 2'd1;
					if (pv_ovf) begin
						st_q <= STAT_OVF;
					end else if (k_q == 2'd0) begin
						if (mode_q == MODE_SUB) begin
							if (pv == WMIN) st_q <= STAT_OVF;
							p1_q <= -pv;
						end else begin
							p1_q <= pv;
						end
					end else if (k_q == 2'd1) begin
						case (mode_q)
							MODE_ADD, MODE_SUB: begin
								if (asum_ovf) st_q <= STAT_OVF;
								n_q <= asum;
							end
							MODE_MUL, MODE_DIV: begin
								n_q <= p1_q;
								d_q <= pv;
							end
							MODE_LT: truth_q <= p1_q < pv;
							MODE_GT: truth_q <= pv < p1_q;
							MODE_LE: truth_q <= !(pv < p1_q);
							default: truth_q <= !(p1_q < pv);
						endcase
					end else begin
						d_q <= pv;
					end
				end
			end
			S_NORM: begin
				// move the sign to the numerator, then start Euclid on the magnitudes
				if (d_q == '0) st_q <= STAT_ZDEN;
				else if (norm_ovf) st_q <= STAT_OVF;
				else if (n_q != '0 && nn == WMIN) st_q <= STAT_OVF;
				n_q   <= nn;
				d_q   <= dd;
				ua_q  <= mag(nn);
				ub_q  <= dd;
				div_q <= 1'b1;
			end
			S_GCD: begin
				if (md_done) begin
					if (md_rem == '0) begin
						g_q  <= ub_q;
						ua_q <= mag(n_q);
					end else begin
						ua_q <= ub_q;
						ub_q <= md_rem;
					end
				end
			end
			S_DIVN: begin
				if (md_done) begin
					rn_q <= n_q[W-1] ? W'(-md_quot) : md_quot;
					ua_q <= d_q;
					ub_q <= g_q;
				end
			end
			S_DIVD: begin
				if (md_done) rd_q <= md_quot;
			end
			S_FLOOR: begin
				if (md_done) rn_q <= fneg ? W'(fq - 1'b1) : fq;
			end
			default: ;
		endcase
	end

	// error items read 0/1 with truth low
	assign rsp.valid      = (state_q == S_DONE);
	assign rsp.status     = st_q;
	assign rsp.result_num = (st_q == STAT_OK) ? 64'(rn_q) : 64'd0;
	assign rsp.result_den = (st_q == STAT_OK) ? 63'(rd_q) : 63'd1;
	assign rsp.truth      = (st_q == STAT_OK) && truth_q;

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready)
		else $error("input taken while a result is pending");

	a_done_in_unit_state: assert property (@(posedge clk) disable iff (!arst_n)
		md_done |-> (state_q == S_MUL || state_q == S_GCD || state_q == S_DIVN ||
			state_q == S_DIVD || state_q == S_FLOOR))
		else $error("unit finished outside a waiting state");

	a_start_after_issue: assert property (@(posedge clk) disable iff (!arst_n)
		go_q |-> (state_q == S_MUL || state_q == S_GCD || state_q == S_DIVN ||
			state_q == S_DIVD || state_q == S_FLOOR))
		else $error("unit started without a waiting state");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.status == STAT_OK || rsp.status == STAT_OVF ||
			rsp.status == STAT_ZDEN))
		else $error("status code out of range");

	a_truth_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.truth) |-> (rsp.status == STAT_OK && rsp.result_den == 63'd1))
		else $error("truth set on an error or fraction result");

endmodule

FILE: bench/cra_check.sv
// Checker for the checked rational ALU: watches both channels, predicts each result and compares.
`timescale 1ns / 1ps
module cra_check
	import cra_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	cra_in_if    req,
	cra_out_if   rsp,
	output int   fails,
	output int   pending
);

	typedef struct packed {
		logic [63:0] num;
		logic [62:0] den;
		logic        truth;
		logic [1:0]  status;
	} rat_result_t;

	rat_result_t expected_q[$];

	localparam longint MIN_WORD = 64'sh8000000000000000;

	function automatic longint mul_chk(input longint a, input longint b, inout logic [1:0] st);
		logic signed [127:0] p;
		if (st != STAT_OK) return 0;
		p = a;
		p = p * b;
		if (p[127:63] != {65{p[63]}}) begin
			st = STAT_OVF;
			return 0;
		end
		return p[63:0];
	endfunction

	function automatic longint add_chk(input longint a, input longint b, inout logic [1:0] st);
		logic signed [64:0] s;
		if (st != STAT_OK) return 0;
		s = a;
		s = s + b;
		if (s[64] != s[63]) begin
			st = STAT_OVF;
			return 0;
		end
		return s[63:0];
	endfunction

	function automatic longint neg_chk(input longint a, inout logic [1:0] st);
		if (st != STAT_OK) return 0;
		if (a == MIN_WORD) begin
			st = STAT_OVF;
			return 0;
		end
		return -a;
	endfunction

	function automatic void reduce(input longint n, input longint d, output longint on,
			output longint od, inout logic [1:0] st);
		longint unsigned x, y, t;
		on = 0;
		od = 1;
		if (st != STAT_OK) return;
		if (d == 0) begin
			st = STAT_ZDEN;
			return;
		end
		if (d < 0) begin
			n = neg_chk(n, st);
			d = neg_chk(d, st);
			if (st != STAT_OK) return;
		end
		if (n == 0) return;
		if (n == MIN_WORD || d == MIN_WORD) begin
			st = STAT_OVF;
			return;
		end
		x = (n < 0) ? -n : n;
		y = d;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		on = n / longint'(x);
		od = d / longint'(x);
	endfunction

	function automatic logic cross_less(input longint an, input longint ad, input longint bn,
			input longint bd, inout logic [1:0] st);
		longint x, y;
		x = mul_chk(an, bd, st);
		y = mul_chk(bn, ad, st);
		return x < y;
	endfunction

	function automatic rat_result_t predict_result(input logic [3:0] mode, input longint an,
			input longint ad, input longint bn, input longint bd);
		rat_result_t r;
		longint n, d, rn, rd, q, m, cp;
		logic [1:0] st;
		logic tr;
		st = STAT_OK;
		rn = 0;
		rd = 1;
		tr = 1'b0;
		case (mode)
			MODE_ADD, MODE_SUB: begin
				n = mul_chk(bn, ad, st);
				if (mode == MODE_SUB) n = neg_chk(n, st);
				cp = mul_chk(an, bd, st);
				n = add_chk(cp, n, st);
				d = mul_chk(ad, bd, st);
				reduce(n, d, rn, rd, st);
			end
			MODE_MUL: begin
				n = mul_chk(an, bn, st);
				d = mul_chk(ad, bd, st);
				reduce(n, d, rn, rd, st);
			end
			MODE_DIV: begin
				n = mul_chk(an, bd, st);
				d = mul_chk(ad, bn, st);
				reduce(n, d, rn, rd, st);
			end
			MODE_NEG: begin
				rn = neg_chk(an, st);
				rd = ad;
			end
			MODE_LT: tr = cross_less(an, ad, bn, bd, st);
			MODE_LE: tr = !cross_less(bn, bd, an, ad, st);
			MODE_GT: tr = cross_less(bn, bd, an, ad, st);
			MODE_GE: tr = !cross_less(an, ad, bn, bd, st);
			MODE_EQ: tr = (an == bn && ad == bd);
			MODE_NE: tr = !(an == bn && ad == bd);
			MODE_FLOOR: begin
				if (ad == 0) st = STAT_ZDEN;
				else if (an == MIN_WORD && ad == -1) st = STAT_OVF;
				else begin
					q = an / ad;
					m = an % ad;
					rn = (m < 0) ? q - 1 : q;
				end
			end
			MODE_NORM: reduce(an, ad, rn, rd, st);
			default: ;
		endcase
		if (st != STAT_OK) begin
			rn = 0;
			rd = 1;
			tr = 1'b0;
		end
		r.num = rn;
		r.den = rd[62:0];
		r.truth = tr;
		r.status = st;
		return r;
	endfunction

	task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
		$display("%0t: mismatch in %s: got %0h, expected %0h", $time, field, got, want);
		fails++;
	endtask

	assign pending = expected_q.size();

	always @(posedge clk) begin
		rat_result_t w;
		if (arst_n) begin
			if (req.valid && req.ready)
				expected_q.push_back(predict_result(req.mode, req.a_num, req.a_den, req.b_num,
					longint'({1'b0, req.b_den})));
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: result item with none expected", $time);
					fails++;
				end else begin
					w = expected_q.pop_front();
					if (rsp.result_num !== w.num) report("result_num", rsp.result_num, w.num);
					if (rsp.result_den !== w.den) report("result_den", rsp.result_den, w.den);
					if (rsp.truth !== w.truth) report("truth", rsp.truth, w.truth);
					if (rsp.status !== w.status) report("status", rsp.status, w.status);
				end
			end
		end
	end

endmodule

FILE: bench/checked_rational_alu_test.sv
// Top of the rational ALU testbench: clock, reset, stimulus, result stalls and verdict.
`timescale 1ns / 1ps
module checked_rational_alu_test;
	import cra_pkg::*;

	localparam longint MAX_WORD = 64'sh7fffffffffffffff;
	localparam longint MIN_WORD = 64'sh8000000000000000;
	localparam int RANDOM_ITEMS = 1030;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fails, pending;
	bit   calm;        // stretch with no idling on either side
	bit   sending_done;

	cra_in_if  req ();
	cra_out_if rsp ();

	checked_rational_alu uut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	cra_check checker_i (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.fails(fails), .pending(pending));

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Short gaps are common, long ones rare.
	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (calm || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Pick a numerator: mostly small so Euclid stays short, some full width, some extremes.
	function automatic longint pick_num();
		int r;
		r = $urandom_range(99);
		if (r < 50) return longint'($urandom_range(2000)) - 1000;
		if (r < 78) return longint'($urandom_range(2097152)) - 1048576;
		if (r < 90) return {$urandom, $urandom};
		case ($urandom_range(5))
			0: return MAX_WORD;
			1: return MIN_WORD;
			2: return 0;
			3: return 1;
			4: return -1;
			default: return longint'(1) << $urandom_range(62);
		endcase
	endfunction

	function automatic longint pick_den();
		longint v;
		v = pick_num();
		if (v < 0) v = ~v;
		return (v == 0) ? 1 : v;
	endfunction

	function automatic longint gcd_of(input longint a, input longint b);
		longint unsigned x, y, t;
		x = (a < 0) ? -a : a;
		y = b;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return (x == 0) ? 1 : x;
	endfunction

	// Hold one item on the input channel until it is taken.
	task automatic send(input logic [3:0] mode, input longint an, input longint ad,
			input longint bn, input longint bd);
		repeat (gap_len()) begin
			@(negedge clk);
			req.valid <= 1'b0;
		end
		@(negedge clk);
		req.valid <= 1'b1;
		req.mode  <= mode;
		req.a_num <= an;
		req.a_den <= ad;
		req.b_num <= bn;
		req.b_den <= bd[62:0];
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	// Receiver: drop ready for random stretches, never when calm.
	initial begin
		int stall;
		stall = 0;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				stall--;
				rsp.ready <= 1'b0;
			end else begin
				stall = gap_len();
				rsp.ready <= (stall == 0);
			end
		end
	end

	initial begin
		longint an, ad, bn, bd, g;
		int r;
		req.valid = 1'b0;
		req.mode  = MODE_ADD;
		req.a_num = '0;
		req.a_den = 64'd1;
		req.b_num = '0;
		req.b_den = 63'd1;
		calm = 1'b0;
		sending_done = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: each mode, field extremes and the error corners
		calm = 1'b1;
		send(MODE_ADD, 1, 2, 1, 3);
		send(MODE_ADD, MAX_WORD, 1, MAX_WORD, 1);          // sum overflow
		send(MODE_SUB, 1, 6, 1, 3);
		send(MODE_SUB, MIN_WORD, 1, 1, 1);
		send(MODE_MUL, MAX_WORD, 1, 2, 1);                 // product overflow
		send(MODE_MUL, -3, 4, 2, 9);
		send(MODE_DIV, 2, 3, 0, 1);                        // divide by zero
		send(MODE_DIV, MAX_WORD, 1, 0, MAX_WORD);          // overflow wins over zero test
		send(MODE_DIV, -5, 7, -10, 21);
		send(MODE_NEG, MIN_WORD, 1, 0, 1);                 // negate most negative word
		send(MODE_NEG, 5, -3, 0, 1);                       // den passed through as is
		send(MODE_LT, 1, 3, 1, 2);
		send(MODE_LE, 1, 2, 1, 2);
		send(MODE_GT, MAX_WORD, 1, 1, MAX_WORD);           // cross product overflow
		send(MODE_GE, -1, 2, 1, 2);
		send(MODE_EQ, 3, 4, 3, 4);
		send(MODE_NE, 3, 4, 3, 5);
		send(MODE_FLOOR, -7, 2, 0, 1);
		send(MODE_FLOOR, 7, 0, 0, 1);                      // zero denominator
		send(MODE_FLOOR, MIN_WORD, -1, 0, 1);              // quotient overflow
		send(MODE_NORM, 4, -6, 0, 1);                      // sign moves to numerator
		send(MODE_NORM, 0, -5, 0, 1);
		send(MODE_NORM, MIN_WORD, 1, 0, 1);
		send(MODE_NORM, 3, MIN_WORD, 0, 1);
		send(4'd13, 1, 1, 1, 1);
		send(4'd15, -1, -1, -1, MAX_WORD);

		// random: mostly normalized operands, some raw ones and unused modes
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 200 == 0) calm = ($urandom_range(3) == 0);
			an = pick_num();
			ad = pick_den();
			bn = pick_num();
			bd = pick_den();
			r = $urandom_range(99);
			if (r < 85) begin
				g = gcd_of(an, ad);
				an = an / g;
				ad = ad / g;
				g = gcd_of(bn, bd);
				bn = bn / g;
				bd = bd / g;
			end else if (r < 95) begin
				ad = pick_num();
				bd = {$urandom, $urandom};
			end
			send($urandom_range(15), an, ad, bn, bd);
		end
		@(negedge clk);
		req.valid <= 1'b0;
		calm = 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#40000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: sim.f
design/cra_pkg.sv
design/cra_in_if.sv
design/cra_out_if.sv
design/cra_muldiv.sv
design/checked_rational_alu.sv
bench/cra_check.sv
bench/checked_rational_alu_test.sv
